FILE: rtl/krt_pkg.sv
// Package for the keyed registry table: sizes, codes and shared structs.
// Used by every module of the block; no dependencies of its own.
package krt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int LIVE_W      = 7;
    localparam int IN_DATA_W   = 136;
    localparam int OUT_DATA_W  = 80;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT         = 3'd0,
        ST_MISS        = 3'd1,
        ST_INSERTED    = 3'd2,
        ST_REPLACED    = 3'd3,
        ST_FULL        = 3'd4,
        ST_ZERO        = 3'd5,
        ST_REMOVED     = 3'd6,
        ST_REMOVE_MISS = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD_LAST,
        S_MOVE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } t_entry;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_entry            wr_data;
    } t_mem_req;

    typedef struct packed {
        t_status            status;
        logic [VAL_W-1:0]   found;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

FILE: rtl/keyed_registry_table.sv
// Keyed registry table: up to 64 key/value pairs packed below a live count.
// Operations run one at a time: a command is taken only in the idle state, and
// the linear scan of live slots sets how long a lookup, insert or remove takes.
// The next command is taken while a result waits in the output register.
// Reset (synchronous, active low) clears the count; slot contents stay undefined.
module keyed_registry_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // opcode[1:0], key[65:2], entry_value[129:66], zero pad
    input  logic [krt_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // status[2:0], found_value[66:3], live_count[73:67], zero pad
    output logic [krt_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    krt_pkg::t_mem_req mem_req;
    krt_pkg::t_entry   rd_data;
    krt_pkg::t_result  res;
    logic              res_valid;
    logic              res_ready;
    logic                            r_out_valid;
    logic [krt_pkg::STATUS_W-1:0]    r_out_status;
    logic [krt_pkg::VAL_W-1:0]       r_out_found;
    logic [krt_pkg::LIVE_W-1:0]      r_out_live;

    krt_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    krt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_s_axis_tvalid),
        .o_cmd_ready (o_s_axis_tready),
        .i_op        (i_s_axis_tdata[1:0]),
        .i_key       (i_s_axis_tdata[65:2]),
        .i_val       (i_s_axis_tdata[129:66]),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out_status <= res.status;
            r_out_found  <= res.found;
            r_out_live   <= krt_pkg::LIVE_W'(res.count);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_live, r_out_found, r_out_status};

endmodule

FILE: rtl/krt_ram.sv
// Slot storage: one key/value pair per slot, one write and one read port.
// Read data is registered. Depends on krt_pkg.
module krt_ram (
    input  logic              i_clk,
    input  krt_pkg::t_mem_req i_req,
    output krt_pkg::t_entry   o_rd_data
);

    krt_pkg::t_entry r_mem [krt_pkg::TABLE_DEPTH];
    krt_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/krt_ctrl.sv
// Sequencer: scans live slots through the RAM, then returns a hit, replaces,
// appends or swaps the last entry into a hole. Depends on krt_pkg and krt_ram timing.
module krt_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    output logic                       o_cmd_ready,
    input  logic [krt_pkg::OP_W-1:0]   i_op,
    input  logic [krt_pkg::KEY_W-1:0]  i_key,
    input  logic [krt_pkg::VAL_W-1:0]  i_val,
    output krt_pkg::t_mem_req          o_mem_req,
    input  krt_pkg::t_entry            i_rd_data,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output krt_pkg::t_result           o_res
);

    krt_pkg::t_state                r_state, n_state;
    logic [krt_pkg::OP_W-1:0]       r_op, n_op;
    logic [krt_pkg::KEY_W-1:0]      r_key, n_key;
    logic [krt_pkg::VAL_W-1:0]      r_val, n_val;
    logic [krt_pkg::COUNT_W-1:0]    r_count, n_count;
    logic [krt_pkg::COUNT_W-1:0]    r_idx, n_idx;
    logic                           r_pend, n_pend;
    logic [krt_pkg::ADDR_W-1:0]     r_rd_addr, n_rd_addr;
    logic [krt_pkg::ADDR_W-1:0]     r_at, n_at;
    krt_pkg::t_status               r_status, n_status;
    logic [krt_pkg::VAL_W-1:0]      r_found, n_found;
    logic                           hit;
    logic                           issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= krt_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_op      <= n_op;
        r_key     <= n_key;
        r_val     <= n_val;
        r_idx     <= n_idx;
        r_rd_addr <= n_rd_addr;
        r_at      <= n_at;
        r_status  <= n_status;
        r_found   <= n_found;
    end

    // data from the read issued last cycle lines up with r_rd_addr
    assign hit   = r_pend && (i_rd_data.key == r_key);
    assign issue = !hit && (r_idx < r_count);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_val     = r_val;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pend    = 1'b0;
        n_rd_addr = r_rd_addr;
        n_at      = r_at;
        n_status  = r_status;
        n_found   = r_found;
        o_mem_req = '0;
        o_cmd_ready = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            krt_pkg::S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_op    = i_op;
                    n_key   = i_key;
                    n_val   = i_val;
                    n_idx   = '0;
                    n_found = '0;
                    if (i_op == krt_pkg::OP_INSERT && i_val == '0) begin
                        n_status = krt_pkg::ST_ZERO;
                        n_state  = krt_pkg::S_DONE;
                    end else begin
                        n_state = krt_pkg::S_SCAN;
                    end
                end
            end
            krt_pkg::S_SCAN: begin
                if (issue) begin
                    o_mem_req.rd_en   = 1'b1;
                    o_mem_req.rd_addr = r_idx[krt_pkg::ADDR_W-1:0];
                    n_rd_addr         = r_idx[krt_pkg::ADDR_W-1:0];
                    n_idx             = r_idx + 1'b1;
                    n_pend            = 1'b1;
                end
                if (hit) begin
                    if (r_op == krt_pkg::OP_INSERT) begin
                        o_mem_req.wr_en       = 1'b1;
                        o_mem_req.wr_addr     = r_rd_addr;
                        o_mem_req.wr_data.key = r_key;
                        o_mem_req.wr_data.val = r_val;
                        n_status              = krt_pkg::ST_REPLACED;
                        n_state               = krt_pkg::S_DONE;
                    end else if (r_op == krt_pkg::OP_REMOVE) begin
                        n_at    = r_rd_addr;
                        n_state = krt_pkg::S_RD_LAST;
                    end else begin
                        n_found  = i_rd_data.val;
                        n_status = krt_pkg::ST_HIT;
                        n_state  = krt_pkg::S_DONE;
                    end
                end else if (r_idx >= r_count) begin
                    n_state = krt_pkg::S_DONE;
                    if (r_op == krt_pkg::OP_INSERT) begin
                        if (r_count < krt_pkg::COUNT_W'(krt_pkg::TABLE_DEPTH)) begin
                            o_mem_req.wr_en       = 1'b1;
                            o_mem_req.wr_addr     = r_count[krt_pkg::ADDR_W-1:0];
                            o_mem_req.wr_data.key = r_key;
                            o_mem_req.wr_data.val = r_val;
                            n_count               = r_count + 1'b1;
                            n_status              = krt_pkg::ST_INSERTED;
                        end else begin
                            n_status = krt_pkg::ST_FULL;
                        end
                    end else if (r_op == krt_pkg::OP_REMOVE) begin
                        n_status = krt_pkg::ST_REMOVE_MISS;
                    end else begin
                        n_status = krt_pkg::ST_MISS;
                    end
                end
            end
            krt_pkg::S_RD_LAST: begin
                o_mem_req.rd_en   = 1'b1;
                o_mem_req.rd_addr = krt_pkg::ADDR_W'(r_count - 1'b1);
                n_state           = krt_pkg::S_MOVE;
            end
            krt_pkg::S_MOVE: begin
                // last entry fills the hole; harmless when the hole is the last slot
                o_mem_req.wr_en   = 1'b1;
                o_mem_req.wr_addr = r_at;
                o_mem_req.wr_data = i_rd_data;
                n_count           = r_count - 1'b1;
                n_status          = krt_pkg::ST_REMOVED;
                n_state           = krt_pkg::S_DONE;
            end
            krt_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = krt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = krt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_res.status = r_status;
    assign o_res.found  = r_found;
    assign o_res.count  = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= krt_pkg::COUNT_W'(krt_pkg::TABLE_DEPTH))
        else $error("live count above table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
        (r_count == $past(r_count) + 1'b1 || r_count == $past(r_count) - 1'b1))
        else $error("live count moved by more than one");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.wr_en |->
        ({1'b0, o_mem_req.wr_addr} <= krt_pkg::COUNT_W'(r_count)))
        else $error("slot write beyond the append point");

    a_no_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == krt_pkg::S_IDLE || r_state == krt_pkg::S_DONE) |->
        !o_mem_req.wr_en)
        else $error("slot write outside an operation");

endmodule
